### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// invariant, disabled in reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("invariant failed");

`endif

### rtl/cib62_pkg.sv
// types, constants and helper functions of the base62 id encoder
// no dependencies
package cib62_pkg;

    localparam int ID_W           = 64;
    localparam int CHAR_W         = 7;
    localparam int MAXD_W         = 4;
    localparam int DIGIT_W        = 6;
    localparam int DIGIT_SLOTS_DEF = 13;

    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = MAXD_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_SENSITIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS     = 1'b1;
    localparam logic              CASE_SENSITIVE_RST = 1'b1;
    localparam logic [MAXD_W-1:0] MAX_DIGITS_RST     = 4'd13;

    // long division by the radix, one chunk of the id per step
    localparam int CHUNK_W     = 16;
    localparam int CHUNK_CNT   = ID_W / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(CHUNK_CNT);
    localparam int X_W         = DIGIT_W + CHUNK_W;
    localparam int RADIX_W     = DIGIT_W + 1;

    localparam int RADIX_FULL  = 62;
    localparam int LOWER_COUNT = 26;
    localparam int RADIX_SHORT = RADIX_FULL - LOWER_COUNT;
    localparam int DEC_COUNT   = 10;

    // reciprocal estimate is low by at most one for any chunk dividend
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 19;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_FULL  =
        RECIP_W'((64'd1 << RECIP_SHIFT) / RADIX_FULL);
    localparam logic [RECIP_W-1:0] RECIP_SHORT =
        RECIP_W'((64'd1 << RECIP_SHIFT) / RADIX_SHORT);

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_NONE     = 7'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMPTY,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_empty;
        logic emit_char;
    } t_cmd;

    typedef struct packed {
        logic value_zero;
        logic at_limit;
        logic count_zero;
        logic count_one;
        logic last_chunk;
        logic out_free;
    } t_sts;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        priority if (int'(d) < DEC_COUNT) begin
            c = ASCII_ZERO + dx;
        end else if (int'(d) < RADIX_SHORT) begin
            c = ASCII_UPPER_A + dx - CHAR_W'(DEC_COUNT);
        end else if (int'(d) < RADIX_FULL) begin
            c = ASCII_LOWER_A + dx - CHAR_W'(RADIX_SHORT);
        end else begin
            c = ASCII_ZERO;
        end
        return c;
    endfunction

endpackage

### rtl/cib62_id_if.sv
// request channel carrying one 64-bit id
// depends on cib62_pkg
interface cib62_id_if import cib62_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] id;

    modport source (output valid, output id, input ready);
    modport sink   (input valid, input id, output ready);
endinterface

### rtl/cib62_char_if.sv
// result channel carrying one encoded character
// depends on cib62_pkg
interface cib62_char_if import cib62_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_empty;
    logic              is_last;

    modport source (output valid, output char_code, output is_empty, output is_last,
                    input ready);
    modport sink   (input valid, input char_code, input is_empty, input is_last,
                    output ready);
endinterface

### rtl/cib62_cfg_if.sv
// configuration write channel, register index and write data
// depends on cib62_pkg
interface cib62_cfg_if import cib62_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cib62_dpath.sv
// datapath: chunked reciprocal divider, digit stack and output register
// depends on cib62_pkg and assert_macros.svh
`include "assert_macros.svh"

module cib62_dpath import cib62_pkg::*; #(
    parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [ID_W-1:0]   i_id,
    input  logic              i_case_sensitive,
    input  logic [MAXD_W-1:0] i_max_digits,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_is_empty,
    output logic              o_is_last
);

    logic [ID_W-1:0]        r_value, n_value;
    logic [DIGIT_W-1:0]     r_rem, n_rem;
    logic [CHUNK_IDX_W-1:0] r_chunk, n_chunk;
    logic [MAXD_W-1:0]      r_count, n_count;
    logic [DIGIT_W-1:0]     r_stack [DIGIT_SLOTS];
    logic [DIGIT_W-1:0]     n_stack [DIGIT_SLOTS];
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_empty, n_empty;
    logic                   r_last, n_last;

    logic [X_W-1:0]         x;
    logic [RECIP_W-1:0]     recip;
    logic [PROD_W-1:0]      prod;
    logic [CHUNK_W-1:0]     q_est;
    logic [X_W-1:0]         qx;
    logic [X_W-1:0]         qd;
    logic [X_W-1:0]         r_full;
    logic [RADIX_W-1:0]     r_est;
    logic [RADIX_W-1:0]     radix;
    logic [RADIX_W-1:0]     rem_wide;
    logic                   fix;
    logic [CHUNK_W-1:0]     q_next;
    logic [DIGIT_W-1:0]     rem_next;
    logic [MAXD_W-1:0]      lim;
    logic                   last_chunk;
    logic                   push;
    logic                   emit;

    // one chunk of the long division
    always_comb begin
        x      = {r_rem, r_value[ID_W-1 -: CHUNK_W]};
        recip  = i_case_sensitive ? RECIP_FULL : RECIP_SHORT;
        radix  = i_case_sensitive ? RADIX_W'(RADIX_FULL) : RADIX_W'(RADIX_SHORT);
        prod   = PROD_W'(x) * PROD_W'(recip);
        q_est  = prod[RECIP_SHIFT +: CHUNK_W];
        qx     = X_W'(q_est);
        // 62 = 64 - 2, 36 = 32 + 4
        qd     = i_case_sensitive ? ((qx << 6) - (qx << 1)) : ((qx << 5) + (qx << 2));
        r_full = x - qd;
        r_est  = r_full[RADIX_W-1:0];
        fix    = (r_est >= radix);
        rem_wide = fix ? (r_est - radix) : r_est;
        rem_next = rem_wide[DIGIT_W-1:0];
        q_next   = q_est + CHUNK_W'(fix);
    end

    always_comb begin
        lim = (int'(i_max_digits) > DIGIT_SLOTS) ? MAXD_W'(DIGIT_SLOTS) : i_max_digits;
        last_chunk = (r_chunk == CHUNK_IDX_W'(CHUNK_CNT - 1));
        push = i_cmd.step && last_chunk;
        emit = i_cmd.emit_char || i_cmd.emit_empty;
    end

    always_comb begin
        o_sts.value_zero = (r_value == '0);
        o_sts.at_limit   = (r_count == lim);
        o_sts.count_zero = (r_count == '0);
        o_sts.count_one  = (r_count == MAXD_W'(1));
        o_sts.last_chunk = last_chunk;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_value = r_value;
        n_rem   = r_rem;
        n_chunk = r_chunk;
        n_count = r_count;
        if (i_cmd.load) begin
            n_value = i_id;
            n_rem   = '0;
            n_chunk = '0;
            n_count = '0;
        end else if (i_cmd.step) begin
            n_value = {r_value[ID_W-CHUNK_W-1:0], q_next};
            n_rem   = last_chunk ? '0 : rem_next;
            n_chunk = last_chunk ? '0 : r_chunk + CHUNK_IDX_W'(1);
            n_count = last_chunk ? r_count + MAXD_W'(1) : r_count;
        end else if (i_cmd.emit_char) begin
            n_count = r_count - MAXD_W'(1);
        end
    end

    // digit stack, newest digit on top
    always_comb begin
        for (int i = 0; i < DIGIT_SLOTS; i++) begin
            n_stack[i] = r_stack[i];
        end
        if (push) begin
            n_stack[0] = rem_next;
            for (int i = 1; i < DIGIT_SLOTS; i++) begin
                n_stack[i] = r_stack[i-1];
            end
        end else if (i_cmd.emit_char) begin
            for (int i = 0; i < DIGIT_SLOTS - 1; i++) begin
                n_stack[i] = r_stack[i+1];
            end
        end
    end

    always_comb begin
        n_char  = r_char;
        n_empty = r_empty;
        n_last  = r_last;
        if (i_cmd.emit_char) begin
            n_char  = digit_char(r_stack[0]);
            n_empty = 1'b0;
            n_last  = (r_count == MAXD_W'(1));
        end else if (i_cmd.emit_empty) begin
            n_char  = CHAR_NONE;
            n_empty = 1'b1;
            n_last  = 1'b1;
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value     <= '0;
            r_rem       <= '0;
            r_chunk     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_value     <= n_value;
            r_rem       <= n_rem;
            r_chunk     <= n_chunk;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stack <= n_stack;
        r_char  <= n_char;
        r_empty <= n_empty;
        r_last  <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_empty  = r_empty;
    assign o_is_last   = r_last;

    `ASSERT_ALWAYS(a_rem_below_radix, i_clk, i_rst_n, r_rem < radix)
    `ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, push, r_count == $past(r_count) + MAXD_W'(1))

endmodule

### rtl/cib62_ctrl.sv
// controller: sequences load, divide steps, empty result and character emission
// depends on cib62_pkg and assert_macros.svh
`include "assert_macros.svh"

module cib62_ctrl import cib62_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (i_sts.value_zero || i_sts.at_limit) begin
                    n_state = i_sts.count_zero ? ST_EMPTY : ST_EMIT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.last_chunk) begin
                    n_state = ST_CHECK;
                end
            end
            ST_EMPTY: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free && i_sts.count_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CHECK: begin
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_EMPTY: begin
                o_cmd.emit_empty = i_sts.out_free;
            end
            ST_EMIT: begin
                o_cmd.emit_char = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_load_to_check, i_clk, i_rst_n, o_cmd.load, r_state == ST_CHECK)
    `ASSERT_IMPL(a_emit_has_digit, i_clk, i_rst_n, o_cmd.emit_char, !i_sts.count_zero)
    `ASSERT_IMPL(a_step_below_limit, i_clk, i_rst_n, o_cmd.step, !i_sts.at_limit)
    `ASSERT_IMPL(a_emit_has_room, i_clk, i_rst_n, o_cmd.emit_char || o_cmd.emit_empty, i_sts.out_free)

endmodule

### rtl/compact_id_base62_encoder.sv
// top level of the base62 / base36 compact id encoder
// depends on cib62_pkg, the channel interfaces, cib62_ctrl and cib62_dpath
//
// usage: i_id takes one 64-bit id per request (valid/ready). o_char returns one
// request per kept character, most significant first, is_last on the final one;
// an id of zero or a max_digits of zero gives one request with is_empty and
// is_last set and char_code zero. i_cfg writes register 0 (case_sensitive,
// radix 62 when set, radix 36 when clear) and register 1 (max_digits), always
// ready; the user must only write it while no id is in flight, unchecked here.
// timing: each digit takes one limit check plus four 16-bit steps of the
// reciprocal divide unit; after the final check the characters are emitted
// at one per cycle while the receiver keeps ready high.
// one id is worked at a time; i_id.ready rises again once the final character
// is in the output register, which may still be waiting for the receiver.
// a stalled receiver holds the output register and pauses emission.
// reset (synchronous, active low) returns to idle, drops any pending result and
// restores case_sensitive = 1 and max_digits = 13.

module compact_id_base62_encoder import cib62_pkg::*; #(
    parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cib62_id_if.sink            i_id,
    cib62_char_if.source        o_char,
    cib62_cfg_if.sink           i_cfg
);

    logic              r_case_sensitive;
    logic [MAXD_W-1:0] r_max_digits;
    t_cmd              cmd;
    t_sts              sts;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_sensitive <= CASE_SENSITIVE_RST;
            r_max_digits     <= MAX_DIGITS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CASE_SENSITIVE: r_case_sensitive <= i_cfg.data[0];
                CFG_MAX_DIGITS:     r_max_digits     <= i_cfg.data[MAXD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cib62_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_id.valid),
        .o_in_ready (i_id.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cib62_dpath #(
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_id             (i_id.id),
        .i_case_sensitive (r_case_sensitive),
        .i_max_digits     (r_max_digits),
        .o_out_valid      (o_char.valid),
        .i_out_ready      (o_char.ready),
        .o_char_code      (o_char.char_code),
        .o_is_empty       (o_char.is_empty),
        .o_is_last        (o_char.is_last)
    );

endmodule

### sim/compact_id_base62_encoder_tb.sv
// testbench of compact_id_base62_encoder: random and directed ids, checked per character
// depends on cib62_pkg, the three channel interfaces and the rtl of the encoder
`timescale 1ns / 1ps

module compact_id_base62_encoder_tb;
    import cib62_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 5000;
    localparam int ITEM_TARGET   = 260;
    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_MAX    = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_empty;
        logic              is_last;
    } t_char_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cib62_id_if   id_bus();
    cib62_char_if char_bus();
    cib62_cfg_if  cfg_bus();

    compact_id_base62_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_id    (id_bus),
        .o_char  (char_bus),
        .i_cfg   (cfg_bus)
    );

    always #4 i_clk = ~i_clk;

    string             digit_alphabet =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    logic [ID_W-1:0]   pending_ids[$];
    t_char_result      predicted_chars[$];
    t_char_result      next_char;
    logic              enc_case_sensitive = CASE_SENSITIVE_RST;
    logic [MAXD_W-1:0] enc_max_digits     = MAX_DIGITS_RST;
    logic              id_fire            = 1'b0;
    int                ids_queued         = 0;
    int                err_count          = 0;
    int                idle_cycles        = 0;
    int                holds_asked        = 0;
    int                holds_served       = 0;
    int                hold_left          = 0;
    int                rx_mode            = 0;
    int                rx_mode_left       = 0;
    int                rx_tick            = 0;
    int                burst_left         = 0;
    int                gap_left           = 0;

    // expected characters of one id under the current register settings
    function automatic void predict_encoding(input logic [ID_W-1:0] id);
        logic [ID_W-1:0]    rest;
        logic [ID_W-1:0]    radix;
        logic [DIGIT_W-1:0] digits[DIGIT_SLOTS_DEF];
        int                 limit;
        int                 kept;
        t_char_result       r;
        radix = enc_case_sensitive ? ID_W'(RADIX_FULL) : ID_W'(RADIX_SHORT);
        limit = (int'(enc_max_digits) > DIGIT_SLOTS_DEF) ? DIGIT_SLOTS_DEF
                                                        : int'(enc_max_digits);
        rest = id;
        kept = 0;
        while (rest != '0 && kept < limit) begin
            digits[kept] = DIGIT_W'(rest % radix);
            rest = rest / radix;
            kept++;
        end
        if (kept == 0) begin
            r.char_code = CHAR_NONE;
            r.is_empty  = 1'b1;
            r.is_last   = 1'b1;
            predicted_chars = {predicted_chars, r};
        end else begin
            for (int k = 0; k < kept; k++) begin
                r.char_code = CHAR_W'(digit_alphabet[digits[kept - 1 - k]]);
                r.is_empty  = 1'b0;
                r.is_last   = (k == kept - 1);
                predicted_chars = {predicted_chars, r};
            end
        end
    endfunction

    function automatic void report_mismatch(input string field, input int want, input int got);
        err_count++;
        if (err_count <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        logic [ID_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0: v = '0;
            1: v = '1;
            2, 3, 4, 5: v = v >> $urandom_range(1, 63);
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_id(input logic [ID_W-1:0] v);
        pending_ids = {pending_ids, v};
        ids_queued++;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            queue_id(random_id());
    endtask

    task automatic drain();
        while (pending_ids.size() != 0 || id_bus.valid || predicted_chars.size() != 0)
            @(posedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // id driver, bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            id_bus.valid <= 1'b0;
        end else if (!id_bus.valid || id_fire) begin
            if (gap_left > 0 || pending_ids.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                id_bus.valid <= 1'b0;
            end else begin
                id_bus.valid <= 1'b1;
                id_bus.id    <= pending_ids.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // character receiver, stall pattern plus long holds on request
    always @(negedge i_clk) begin
        rx_tick++;
        if (!i_rst_n) begin
            char_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            char_bus.ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            char_bus.ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 120);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: char_bus.ready <= 1'b1;
                1: char_bus.ready <= 1'($urandom_range(0, 1));
                2: char_bus.ready <= ($urandom_range(0, 3) == 0);
                default: char_bus.ready <= rx_tick[2];
            endcase
        end
    end

    // monitor: register shadow, prediction, checking, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            id_fire            <= 1'b0;
            enc_case_sensitive = CASE_SENSITIVE_RST;
            enc_max_digits     = MAX_DIGITS_RST;
            idle_cycles        = 0;
        end else begin
            id_fire <= id_bus.valid && id_bus.ready;
            if (char_bus.valid && char_bus.ready) begin
                if (predicted_chars.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("%0t: unexpected request, expected none actual %0h/%b/%b",
                                 $time, char_bus.char_code, char_bus.is_empty,
                                 char_bus.is_last);
                end else begin
                    next_char = predicted_chars.pop_front();
                    if (char_bus.char_code !== next_char.char_code)
                        report_mismatch("char_code", next_char.char_code, char_bus.char_code);
                    if (char_bus.is_empty !== next_char.is_empty)
                        report_mismatch("is_empty", next_char.is_empty, char_bus.is_empty);
                    if (char_bus.is_last !== next_char.is_last)
                        report_mismatch("is_last", next_char.is_last, char_bus.is_last);
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_CASE_SENSITIVE: enc_case_sensitive = cfg_bus.data[0];
                    CFG_MAX_DIGITS:     enc_max_digits     = cfg_bus.data;
                    default: ;
                endcase
            end
            if (id_bus.valid && id_bus.ready)
                predict_encoding(id_bus.id);
            if ((id_bus.valid && id_bus.ready) || (char_bus.valid && char_bus.ready)
                    || (cfg_bus.valid && cfg_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: watchdog expired", $time);
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        id_bus.valid   = 1'b0;
        id_bus.id      = '0;
        char_bus.ready = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = CFG_CASE_SENSITIVE;
        cfg_bus.data   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: radix 62, 13 digits
        queue_id(64'd0);
        queue_id(64'd1);
        queue_id(64'd9);
        queue_id(64'd10);
        queue_id(64'd35);
        queue_id(64'd36);
        queue_id(64'd61);
        queue_id(64'd62);
        queue_id(64'd3843);
        queue_id(64'd839299365868340223);
        queue_id(64'd839299365868340224);
        queue_id(64'h8000_0000_0000_0000);
        queue_id('1);
        queue_random(20);
        holds_asked++;
        drain();

        // radix 36, longest id fills every slot
        write_reg(CFG_CASE_SENSITIVE, 4'd0);
        write_reg(CFG_MAX_DIGITS, 4'd13);
        queue_id(64'd35);
        queue_id(64'd36);
        queue_id(64'd4738381338321616895);
        queue_id(64'd4738381338321616896);
        queue_id('1);
        queue_random(25);
        drain();

        // no digits kept
        write_reg(CFG_CASE_SENSITIVE, 4'd1);
        write_reg(CFG_MAX_DIGITS, 4'd0);
        queue_id(64'd0);
        queue_id('1);
        queue_random(5);
        drain();

        write_reg(CFG_MAX_DIGITS, 4'd1);
        queue_id(64'd61);
        queue_id(64'd62);
        queue_random(15);
        drain();

        // limit above the slot count
        write_reg(CFG_CASE_SENSITIVE, 4'd0);
        write_reg(CFG_MAX_DIGITS, 4'd15);
        queue_id('1);
        queue_random(20);
        holds_asked++;
        drain();

        write_reg(CFG_CASE_SENSITIVE, 4'd1);
        write_reg(CFG_MAX_DIGITS, 4'd14);
        queue_id('1);
        queue_random(15);
        drain();

        while (ids_queued < ITEM_TARGET) begin
            write_reg(CFG_CASE_SENSITIVE, 4'($urandom_range(0, 1)));
            write_reg(CFG_MAX_DIGITS, 4'($urandom_range(0, 15)));
            queue_random($urandom_range(10, 30));
            if ($urandom_range(0, 3) == 0)
                holds_asked++;
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && predicted_chars.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
